// ===== src/abi_pkg.sv =====
// ----------------------------------------------------------------------------
// Breakpoint interpolator package
// Shared constants, codes, state types and the interpolation operand struct.
// ----------------------------------------------------------------------------
`default_nettype none

package abi_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int POS_W         = 24;
   localparam int DATA_W        = 32;
   localparam int NUM_FIELDS    = 6;
   localparam int NUM_APERTURES = 4;
   localparam int ENTRY_W       = NUM_FIELDS * DATA_W;
   localparam int DIFF_W        = DATA_W + 2;
   localparam int PROD_W        = DIFF_W + FRACTION_BITS + 1;
   localparam int MAG_W         = PROD_W - 1;
   localparam int STEP_W        = $clog2(MAG_W);
   localparam int FIELD_W       = $clog2(NUM_FIELDS);

   localparam logic [POS_W-1:0] FRAC_ONE = POS_W'(1) << FRACTION_BITS;
   localparam logic [FRACTION_BITS-1:0] FRAC_MASK = {FRACTION_BITS{1'b1}};

   typedef enum logic [1:0] {
      REQ_DEFINE = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RDA,
      S_RDB,
      S_LDB,
      S_CALC,
      S_WAIT,
      S_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      MODE_DIRECT,
      MODE_DUP,
      MODE_LERP
   } mode_type;

   typedef enum logic [1:0] {
      L_IDLE,
      L_MUL,
      L_DIV,
      L_DONE
   } lerp_state_type;

   typedef struct packed {
      logic [DATA_W:0]        a;
      logic [DATA_W:0]        b;
      logic [FRACTION_BITS-1:0] dp;
      logic [FRACTION_BITS-1:0] span;
   } lerp_op_type;

endpackage

`default_nettype wire

// ===== src/abi_if.sv =====
// ----------------------------------------------------------------------------
// Breakpoint interpolator channels
// Valid/ready interfaces for the request and the response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface abi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [23:0] position;
   logic [31:0] aperture_one;
   logic [31:0] aperture_two;
   logic [31:0] aperture_three;
   logic [31:0] aperture_four;
   logic signed [31:0] offset_x;
   logic signed [31:0] offset_y;

   modport source (output valid, req_type, position, aperture_one, aperture_two,
                   aperture_three, aperture_four, offset_x, offset_y, input ready);
   modport sink (input valid, req_type, position, aperture_one, aperture_two,
                 aperture_three, aperture_four, offset_x, offset_y, output ready);
endinterface

interface abi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_aperture_one;
   logic [31:0] result_aperture_two;
   logic [31:0] result_aperture_three;
   logic [31:0] result_aperture_four;
   logic signed [31:0] result_offset_x;
   logic signed [31:0] result_offset_y;
   logic [1:0]  status;

   modport source (output valid, result_aperture_one, result_aperture_two,
                   result_aperture_three, result_aperture_four, result_offset_x,
                   result_offset_y, status, input ready);
   modport sink (input valid, result_aperture_one, result_aperture_two,
                 result_aperture_three, result_aperture_four, result_offset_x,
                 result_offset_y, status, output ready);
endinterface

`default_nettype wire

// ===== src/aperture_breakpoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// Aperture breakpoint interpolator
// Ordered breakpoint table with piecewise linear lookup over one metre.
// ----------------------------------------------------------------------------
// The request channel carries define, query, clear and no-operation items; the
// response channel returns exactly one item for each request, in order.
// Define, clear and no-operation items pass from acceptance through the done
// state to a response. A query scans the stored positions one per cycle, reads
// two table rows from the entry RAM in states RDA, RDB and LDB, and then, when
// it falls between two breakpoints, runs the shared interpolation unit once
// per field: a multiply step, the serial divider and a handoff back to the
// sequencer. The serial divider takes most of the query time. Queries that
// land on a table end or on a duplicated position finish after the scan and
// the row reads.
// The block takes one item at a time; it is ready again once the response is
// loaded into the output register, even while that response waits.
// Reset empties the table and drops any pending response. A stalled receiver
// holds the response item steady and keeps the block from finishing the next.
// ----------------------------------------------------------------------------
`default_nettype none

module aperture_breakpoint_interpolator (
   input wire logic   clock,
   input wire logic   reset,
   abi_req_if.sink    req_chan,
   abi_rsp_if.source  rsp_chan
);

   abi_pkg::seq_state_type state_ff, state_in;
   abi_pkg::mode_type      mode_ff, mode_in;
   logic [abi_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [abi_pkg::FRACTION_BITS-1:0] last_pos_ff, last_pos_in;
   logic [abi_pkg::FRACTION_BITS-1:0] pos_ff [abi_pkg::TABLE_ENTRIES];
   logic [abi_pkg::FRACTION_BITS-1:0] pos_in [abi_pkg::TABLE_ENTRIES];
   logic [abi_pkg::FRACTION_BITS-1:0] frac_ff, frac_in;
   logic                              one_ff, one_in;
   logic [abi_pkg::IDX_W-1:0]         scan_ff, scan_in;
   logic                              found_ff, found_in;
   logic [abi_pkg::IDX_W-1:0]         j_ff, j_in;
   logic                              prev_eq_ff, prev_eq_in;
   logic                              dup_ff, dup_in;
   logic [abi_pkg::FRACTION_BITS-1:0] lo_pos_ff, lo_pos_in;
   logic [abi_pkg::FRACTION_BITS-1:0] hi_pos_ff, hi_pos_in;
   logic [abi_pkg::IDX_W-1:0]         ib_ff, ib_in;
   logic [abi_pkg::ENTRY_W-1:0]       va_ff, va_in;
   logic [abi_pkg::ENTRY_W-1:0]       vb_ff, vb_in;
   logic [abi_pkg::FIELD_W-1:0]       fld_ff, fld_in;
   logic [abi_pkg::DATA_W-1:0]        res_ff [abi_pkg::NUM_FIELDS];
   logic [abi_pkg::DATA_W-1:0]        res_in [abi_pkg::NUM_FIELDS];
   logic [1:0]                        status_ff, status_in;
   logic                              out_valid_ff, out_valid_in;
   logic [abi_pkg::DATA_W-1:0]        out_res_ff [abi_pkg::NUM_FIELDS];
   logic [abi_pkg::DATA_W-1:0]        out_res_in [abi_pkg::NUM_FIELDS];
   logic [1:0]                        out_status_ff, out_status_in;

   logic                              ram_we;
   logic [abi_pkg::IDX_W-1:0]         ram_waddr;
   logic [abi_pkg::ENTRY_W-1:0]       ram_wdata;
   logic [abi_pkg::IDX_W-1:0]         ram_raddr;
   logic [abi_pkg::ENTRY_W-1:0]       ram_rdata;

   logic                              lerp_start;
   abi_pkg::lerp_op_type              lerp_op;
   logic                              lerp_done;
   logic [abi_pkg::DATA_W-1:0]        lerp_result;

   logic [abi_pkg::FRACTION_BITS-1:0] def_frac;
   logic [abi_pkg::IDX_W-1:0]         last_idx;
   logic [abi_pkg::FRACTION_BITS-1:0] scan_pos;
   logic [abi_pkg::DATA_W-1:0]        fa;
   logic [abi_pkg::DATA_W-1:0]        fb;

   abi_ram #(
      .WIDTH(abi_pkg::ENTRY_W),
      .DEPTH(abi_pkg::TABLE_ENTRIES)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   abi_lerp u_lerp (
      .clock(clock),
      .reset(reset),
      .start(lerp_start),
      .op(lerp_op),
      .done(lerp_done),
      .result(lerp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abi_pkg::S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      last_pos_ff   <= last_pos_in;
      pos_ff        <= pos_in;
      frac_ff       <= frac_in;
      one_ff        <= one_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      j_ff          <= j_in;
      prev_eq_ff    <= prev_eq_in;
      dup_ff        <= dup_in;
      lo_pos_ff     <= lo_pos_in;
      hi_pos_ff     <= hi_pos_in;
      ib_ff         <= ib_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      fld_ff        <= fld_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      out_res_ff    <= out_res_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      last_pos_in   = last_pos_ff;
      pos_in        = pos_ff;
      frac_in       = frac_ff;
      one_in        = one_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      j_in          = j_ff;
      prev_eq_in    = prev_eq_ff;
      dup_in        = dup_ff;
      lo_pos_in     = lo_pos_ff;
      hi_pos_in     = hi_pos_ff;
      ib_in         = ib_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      fld_in        = fld_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      out_status_in = out_status_ff;

      ram_we     = 1'b0;
      ram_waddr  = cnt_ff[abi_pkg::IDX_W-1:0];
      ram_wdata  = {req_chan.offset_y, req_chan.offset_x, req_chan.aperture_four,
                    req_chan.aperture_three, req_chan.aperture_two,
                    req_chan.aperture_one};
      ram_raddr  = ib_ff;
      lerp_start = 1'b0;
      req_chan.ready = (state_ff == abi_pkg::S_IDLE);

      def_frac = (req_chan.position == abi_pkg::FRAC_ONE) ? abi_pkg::FRAC_MASK
               : req_chan.position[abi_pkg::FRACTION_BITS-1:0];
      last_idx = abi_pkg::IDX_W'(cnt_ff - 1'b1);
      scan_pos = pos_ff[scan_ff];
      fa = va_ff[fld_ff*abi_pkg::DATA_W +: abi_pkg::DATA_W];
      fb = vb_ff[fld_ff*abi_pkg::DATA_W +: abi_pkg::DATA_W];
      lerp_op.a    = (fld_ff < abi_pkg::FIELD_W'(abi_pkg::NUM_APERTURES))
                   ? {1'b0, fa} : {fa[abi_pkg::DATA_W-1], fa};
      lerp_op.b    = (fld_ff < abi_pkg::FIELD_W'(abi_pkg::NUM_APERTURES))
                   ? {1'b0, fb} : {fb[abi_pkg::DATA_W-1], fb};
      lerp_op.dp   = frac_ff - lo_pos_ff;
      lerp_op.span = hi_pos_ff - lo_pos_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         abi_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               for (int f = 0; f < abi_pkg::NUM_FIELDS; f++) begin
                  res_in[f] = '0;
               end
               status_in = abi_pkg::ST_OK;
               state_in  = abi_pkg::S_DONE;
               unique case (abi_pkg::req_code_type'(req_chan.req_type))
                  abi_pkg::REQ_DEFINE: begin
                     if (cnt_ff == abi_pkg::CNT_W'(abi_pkg::TABLE_ENTRIES)) begin
                        status_in = abi_pkg::ST_FULL;
                     end else if (cnt_ff != '0 && def_frac < last_pos_ff) begin
                        status_in = abi_pkg::ST_ORDER;
                     end else begin
                        ram_we = 1'b1;
                        pos_in[cnt_ff[abi_pkg::IDX_W-1:0]] = def_frac;
                        last_pos_in = def_frac;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  abi_pkg::REQ_QUERY: begin
                     if (cnt_ff == '0) begin
                        status_in = abi_pkg::ST_EMPTY;
                     end else begin
                        frac_in    = req_chan.position[abi_pkg::FRACTION_BITS-1:0];
                        one_in     = (req_chan.position == abi_pkg::FRAC_ONE);
                        scan_in    = '0;
                        found_in   = 1'b0;
                        prev_eq_in = 1'b0;
                        dup_in     = 1'b0;
                        state_in   = abi_pkg::S_SCAN;
                     end
                  end
                  abi_pkg::REQ_CLEAR: begin
                     cnt_in = '0;
                  end
                  abi_pkg::REQ_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         abi_pkg::S_SCAN: begin
            if (scan_pos <= frac_ff) begin
               found_in   = 1'b1;
               j_in       = scan_ff;
               lo_pos_in  = scan_pos;
               dup_in     = (scan_pos == frac_ff) && prev_eq_ff;
               prev_eq_in = (scan_pos == frac_ff);
            end else begin
               hi_pos_in = scan_pos;
            end
            if (scan_pos > frac_ff || scan_ff == last_idx) begin
               state_in = abi_pkg::S_RDA;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         abi_pkg::S_RDA: begin
            if (one_ff) begin
               mode_in   = abi_pkg::MODE_DIRECT;
               ram_raddr = last_idx;
            end else if (!found_ff) begin
               mode_in   = abi_pkg::MODE_DIRECT;
               ram_raddr = '0;
            end else if (dup_ff) begin
               mode_in   = abi_pkg::MODE_DUP;
               ram_raddr = j_ff - 1'b1;
               ib_in     = j_ff;
            end else if (j_ff == last_idx) begin
               mode_in   = abi_pkg::MODE_DIRECT;
               ram_raddr = last_idx;
            end else begin
               mode_in   = abi_pkg::MODE_LERP;
               ram_raddr = j_ff;
               ib_in     = j_ff + 1'b1;
            end
            state_in = abi_pkg::S_RDB;
         end
         abi_pkg::S_RDB: begin
            va_in    = ram_rdata;
            state_in = abi_pkg::S_LDB;
         end
         abi_pkg::S_LDB: begin
            vb_in    = ram_rdata;
            fld_in   = '0;
            state_in = abi_pkg::S_CALC;
         end
         abi_pkg::S_CALC: begin
            if (mode_ff != abi_pkg::MODE_LERP) begin
               for (int f = 0; f < abi_pkg::NUM_FIELDS; f++) begin
                  if (mode_ff == abi_pkg::MODE_DUP && f < abi_pkg::NUM_APERTURES &&
                      vb_ff[f*abi_pkg::DATA_W +: abi_pkg::DATA_W] <
                      va_ff[f*abi_pkg::DATA_W +: abi_pkg::DATA_W]) begin
                     res_in[f] = vb_ff[f*abi_pkg::DATA_W +: abi_pkg::DATA_W];
                  end else begin
                     res_in[f] = va_ff[f*abi_pkg::DATA_W +: abi_pkg::DATA_W];
                  end
               end
            end
            if (mode_ff == abi_pkg::MODE_LERP) begin
               lerp_start = 1'b1;
               state_in   = abi_pkg::S_WAIT;
            end else begin
               state_in = abi_pkg::S_DONE;
            end
         end
         abi_pkg::S_WAIT: begin
            if (lerp_done) begin
               res_in[fld_ff] = lerp_result;
               if (fld_ff == abi_pkg::FIELD_W'(abi_pkg::NUM_FIELDS - 1)) begin
                  state_in = abi_pkg::S_DONE;
               end else begin
                  fld_in   = fld_ff + 1'b1;
                  state_in = abi_pkg::S_CALC;
               end
            end
         end
         abi_pkg::S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_res_in    = res_ff;
               out_status_in = status_ff;
               state_in      = abi_pkg::S_IDLE;
            end
         end
         default: state_in = abi_pkg::S_IDLE;
      endcase
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.result_aperture_one   = out_res_ff[0];
   assign rsp_chan.result_aperture_two   = out_res_ff[1];
   assign rsp_chan.result_aperture_three = out_res_ff[2];
   assign rsp_chan.result_aperture_four  = out_res_ff[3];
   assign rsp_chan.result_offset_x       = out_res_ff[4];
   assign rsp_chan.result_offset_y       = out_res_ff[5];
   assign rsp_chan.status                = out_status_ff;

endmodule

`default_nettype wire

// ===== src/abi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module abi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== src/abi_lerp.sv =====
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes a + ((b - a) * dp) / span with one multiply and a serial divider
// that produces one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module abi_lerp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire abi_pkg::lerp_op_type op,
   output logic                      done,
   output logic [abi_pkg::DATA_W-1:0] result
);

   abi_pkg::lerp_state_type state_ff, state_in;
   logic [abi_pkg::DATA_W-1:0]        a_ff, a_in;
   logic signed [abi_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic [abi_pkg::FRACTION_BITS-1:0] dp_ff, dp_in;
   logic [abi_pkg::FRACTION_BITS-1:0] span_ff, span_in;
   logic                              neg_ff, neg_in;
   logic [abi_pkg::FRACTION_BITS-1:0] rem_ff, rem_in;
   logic [abi_pkg::MAG_W-1:0]         quo_ff, quo_in;
   logic [abi_pkg::STEP_W-1:0]        step_ff, step_in;

   logic signed [abi_pkg::PROD_W-1:0] prod;
   logic signed [abi_pkg::PROD_W-1:0] prod_neg;
   logic [abi_pkg::FRACTION_BITS:0]   rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abi_pkg::L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      diff_ff <= diff_in;
      dp_ff   <= dp_in;
      span_ff <= span_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      diff_in  = diff_ff;
      dp_in    = dp_ff;
      span_in  = span_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      done     = 1'b0;
      result   = neg_ff ? (a_ff - quo_ff[abi_pkg::DATA_W-1:0])
                        : (a_ff + quo_ff[abi_pkg::DATA_W-1:0]);
      prod     = diff_ff * $signed({1'b0, dp_ff});
      prod_neg = -prod;
      rem_sh   = {rem_ff, quo_ff[abi_pkg::MAG_W-1]};

      unique case (state_ff)
         abi_pkg::L_IDLE: begin
            if (start) begin
               a_in    = op.a[abi_pkg::DATA_W-1:0];
               diff_in = $signed({op.b[abi_pkg::DATA_W], op.b})
                       - $signed({op.a[abi_pkg::DATA_W], op.a});
               dp_in   = op.dp;
               span_in = op.span;
               state_in = abi_pkg::L_MUL;
            end
         end
         abi_pkg::L_MUL: begin
            neg_in  = prod[abi_pkg::PROD_W-1];
            quo_in  = prod[abi_pkg::PROD_W-1] ? prod_neg[abi_pkg::MAG_W-1:0]
                                               : prod[abi_pkg::MAG_W-1:0];
            rem_in  = '0;
            step_in = '0;
            state_in = abi_pkg::L_DIV;
         end
         abi_pkg::L_DIV: begin
            if (rem_sh >= {1'b0, span_ff}) begin
               rem_in = abi_pkg::FRACTION_BITS'(rem_sh - {1'b0, span_ff});
               quo_in = {quo_ff[abi_pkg::MAG_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[abi_pkg::FRACTION_BITS-1:0];
               quo_in = {quo_ff[abi_pkg::MAG_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == abi_pkg::STEP_W'(abi_pkg::MAG_W - 1)) begin
               state_in = abi_pkg::L_DONE;
            end
         end
         abi_pkg::L_DONE: begin
            done     = 1'b1;
            state_in = abi_pkg::L_IDLE;
         end
         default: state_in = abi_pkg::L_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/abi_checker.sv =====
// ----------------------------------------------------------------------------
// Breakpoint interpolator checker
// Port-level assertions on the response channel and the query sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module abi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_aperture_one,
   input wire logic [31:0] rsp_offset_y,
   input wire logic [1:0]  rsp_status
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_aperture_one))
      else $error("Response item dropped or changed while stalled.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == abi_pkg::REQ_QUERY |=> !req_ready)
      else $error("Request accepted during a query.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != abi_pkg::ST_OK |->
         rsp_aperture_one == '0 && rsp_offset_y == '0)
      else $error("Rejected item carries nonzero results.");

endmodule

bind aperture_breakpoint_interpolator abi_checker u_abi_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_type(req_chan.req_type),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_aperture_one(rsp_chan.result_aperture_one),
   .rsp_offset_y(rsp_chan.result_offset_y),
   .rsp_status(rsp_chan.status)
);

`default_nettype wire

// ===== verif/abi_tb_if.sv =====
// ----------------------------------------------------------------------------
// Breakpoint interpolator test channels
// Item types the testbench moves through the block's request and response interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The request and response interfaces come from the RTL file abi_if.sv; this
// file only holds the item types the testbench moves through them.
package abi_tb_pkg;

   typedef struct {
      abi_pkg::req_code_type kind;
      logic [23:0]       position;
      logic [31:0]       aperture [4];
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
   } lookup_request_type;

   typedef struct {
      logic [31:0]       aperture [4];
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
      abi_pkg::status_type status;
   } lookup_answer_type;
endpackage

// ===== verif/tb_aperture_breakpoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// Breakpoint interpolator testbench
// Drives define, query, clear and no-operation items through the block, keeps
// its own copy of the breakpoint table, and checks every response against the
// interpolation it predicts, under several patterns of idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aperture_breakpoint_interpolator;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   abi_req_if req_chan ();
   abi_rsp_if rsp_chan ();

   aperture_breakpoint_interpolator dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Table model.
   logic [15:0]        tbl_pos [abi_pkg::TABLE_ENTRIES];
   logic [31:0]        tbl_ap  [abi_pkg::TABLE_ENTRIES][4];
   logic signed [31:0] tbl_x   [abi_pkg::TABLE_ENTRIES];
   logic signed [31:0] tbl_y   [abi_pkg::TABLE_ENTRIES];
   int                 tbl_count;

   abi_tb_pkg::lookup_answer_type pending_answers [$];
   int  error_count = 0;
   int  accepted_requests = 0;
   int  checked_answers = 0;
   int  query_count = 0;
   int  idle_send_pct = 0;
   int  stall_recv_pct = 0;
   int  quiet_cycles = 0;

   function automatic abi_tb_pkg::lookup_answer_type entry_answer(int e);
      abi_tb_pkg::lookup_answer_type r;
      for (int j = 0; j < 4; j++) r.aperture[j] = tbl_ap[e][j];
      r.off_x = tbl_x[e];
      r.off_y = tbl_y[e];
      r.status = abi_pkg::ST_OK;
      return r;
   endfunction

   function automatic longint blend(longint a, longint b, longint dp, longint span);
      return a + ((b - a) * dp) / span;
   endfunction

   // Applies one request to the table model and returns the answer it causes.
   function automatic abi_tb_pkg::lookup_answer_type interpolate_request(
         abi_tb_pkg::lookup_request_type q);
      abi_tb_pkg::lookup_answer_type r, ra, rb;
      logic [15:0] frac;
      logic [15:0] ext_pos [abi_pkg::TABLE_ENTRIES + 2];
      int ext_src [abi_pkg::TABLE_ENTRIES + 2];
      int n, k, dup;
      longint va, vb;
      r.aperture = '{default: '0};
      r.off_x = 0;
      r.off_y = 0;
      r.status = abi_pkg::ST_OK;
      n = 0;
      dup = -1;
      frac = (q.position == abi_pkg::FRAC_ONE) ? 16'hFFFF : q.position[15:0];
      case (q.kind)
         abi_pkg::REQ_CLEAR: begin
            tbl_count = 0;
         end
         abi_pkg::REQ_DEFINE: begin
            if (tbl_count >= abi_pkg::TABLE_ENTRIES) begin
               r.status = abi_pkg::ST_FULL;
            end else if (tbl_count > 0 && frac < tbl_pos[tbl_count-1]) begin
               r.status = abi_pkg::ST_ORDER;
            end else begin
               tbl_pos[tbl_count] = frac;
               for (int j = 0; j < 4; j++) tbl_ap[tbl_count][j] = q.aperture[j];
               tbl_x[tbl_count] = q.off_x;
               tbl_y[tbl_count] = q.off_y;
               tbl_count++;
            end
         end
         abi_pkg::REQ_QUERY: begin
            if (tbl_count == 0) begin
               r.status = abi_pkg::ST_EMPTY;
            end else if (tbl_count == 1) begin
               r = entry_answer(0);
            end else begin
               frac = q.position[15:0];
               if (longint'(tbl_pos[0]) * 1000 > 65536) begin
                  ext_pos[n] = 0; ext_src[n] = 0; n++;
               end
               for (int i = 0; i < tbl_count; i++) begin
                  ext_pos[n] = tbl_pos[i]; ext_src[n] = i; n++;
               end
               if (longint'(tbl_pos[tbl_count-1]) * 100 < 65536 * 99) begin
                  ext_pos[n] = 16'hFFFF; ext_src[n] = tbl_count - 1; n++;
               end
               if (q.position == abi_pkg::FRAC_ONE) begin
                  r = entry_answer(ext_src[n-1]);
               end else begin
                  k = 0;
                  while (k < n && ext_pos[k] <= frac) k++;
                  if (k == 0) begin
                     r = entry_answer(ext_src[0]);
                  end else if (k == n) begin
                     r = entry_answer(ext_src[n-1]);
                  end else begin
                     ra = entry_answer(ext_src[k-1]);
                     rb = entry_answer(ext_src[k]);
                     for (int j = 0; j < 4; j++) begin
                        va = longint'({1'b0, ra.aperture[j]});
                        vb = longint'({1'b0, rb.aperture[j]});
                        r.aperture[j] = 32'(blend(va, vb, frac - ext_pos[k-1],
                                                  ext_pos[k] - ext_pos[k-1]));
                     end
                     r.off_x = 32'(blend(ra.off_x, rb.off_x, frac - ext_pos[k-1],
                                         ext_pos[k] - ext_pos[k-1]));
                     r.off_y = 32'(blend(ra.off_y, rb.off_y, frac - ext_pos[k-1],
                                         ext_pos[k] - ext_pos[k-1]));
                  end
                  for (int i = 0; i + 1 < n; i++)
                     if (ext_pos[i] == ext_pos[i+1] && ext_pos[i+1] == frac) dup = i;
                  if (dup >= 0) begin
                     ra = entry_answer(ext_src[dup]);
                     rb = entry_answer(ext_src[dup+1]);
                     for (int j = 0; j < 4; j++)
                        r.aperture[j] = (ra.aperture[j] > rb.aperture[j]) ?
                                        rb.aperture[j] : ra.aperture[j];
                     r.off_x = ra.off_x;
                     r.off_y = ra.off_y;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Request driver, at the falling edge. Typed rows replace the predicted
   // status and first aperture field with the values read off by hand.
   task automatic send_request(abi_tb_pkg::lookup_request_type q, bit typed = 1'b0,
                               abi_pkg::status_type typed_status = abi_pkg::ST_OK,
                               logic [31:0] typed_ap = '0);
      abi_tb_pkg::lookup_answer_type ans;
      while (idle_send_pct > 0 && $urandom_range(99, 0) < idle_send_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.req_type       <= q.kind;
      req_chan.position       <= q.position;
      req_chan.aperture_one   <= q.aperture[0];
      req_chan.aperture_two   <= q.aperture[1];
      req_chan.aperture_three <= q.aperture[2];
      req_chan.aperture_four  <= q.aperture[3];
      req_chan.offset_x       <= q.off_x;
      req_chan.offset_y       <= q.off_y;
      do @(posedge clock); while (!req_chan.ready);
      ans = interpolate_request(q);
      if (typed) begin
         ans.status = typed_status;
         ans.aperture[0] = typed_ap;
      end
      pending_answers.insert(pending_answers.size(), ans);
      accepted_requests++;
      if (q.kind == abi_pkg::REQ_QUERY) query_count++;
      @(negedge clock);
   endtask

   function automatic abi_tb_pkg::lookup_request_type make_request(
         abi_pkg::req_code_type kind, logic [23:0] position);
      abi_tb_pkg::lookup_request_type q;
      q.kind = kind;
      q.position = position;
      for (int j = 0; j < 4; j++) q.aperture[j] = $urandom();
      q.off_x = $urandom();
      q.off_y = $urandom();
      return q;
   endfunction

   // Response checker, at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         abi_tb_pkg::lookup_answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response, status %0d", $time, rsp_chan.status);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            checked_answers++;
            if (rsp_chan.result_aperture_one !== want.aperture[0] ||
                rsp_chan.result_aperture_two !== want.aperture[1] ||
                rsp_chan.result_aperture_three !== want.aperture[2] ||
                rsp_chan.result_aperture_four !== want.aperture[3] ||
                rsp_chan.result_offset_x !== want.off_x ||
                rsp_chan.result_offset_y !== want.off_y ||
                rsp_chan.status !== want.status) begin
               $display("%0t: mismatch expected %h %h %h %h %h %h st %0d", $time,
                        want.aperture[0], want.aperture[1], want.aperture[2],
                        want.aperture[3], want.off_x, want.off_y, want.status);
               $display("%0t:          actual %h %h %h %h %h %h st %0d", $time,
                        rsp_chan.result_aperture_one, rsp_chan.result_aperture_two,
                        rsp_chan.result_aperture_three, rsp_chan.result_aperture_four,
                        rsp_chan.result_offset_x, rsp_chan.result_offset_y,
                        rsp_chan.status);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls, at the falling edge.
   always @(negedge clock)
      rsp_chan.ready <= !(stall_recv_pct > 0 && $urandom_range(99, 0) < stall_recv_pct);

   // Watchdog over cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL aperture_breakpoint_interpolator");
         $finish;
      end
   end

   typedef struct {
      abi_pkg::req_code_type kind;
      logic [23:0]  position;
      logic [31:0]  ap;
      logic [31:0]  off;
      logic         typed;
      abi_pkg::status_type status;
      logic [31:0]  want_ap;
   } directed_row_type;

   // Directed rows; typed rows also carry a hand-read answer for status and
   // the first aperture field.
   directed_row_type directed_rows [21] = '{
      '{abi_pkg::REQ_QUERY,  24'h000000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_EMPTY, 32'h0},
      '{abi_pkg::REQ_NOP,    24'h000000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_DEFINE, 24'h008000, 32'hFFFFFFFF, 32'h80000000, 1'b1,
        abi_pkg::ST_OK, 32'h0},
      '{abi_pkg::REQ_QUERY,  24'hFF1234, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,
        32'hFFFFFFFF},
      '{abi_pkg::REQ_DEFINE, 24'h004000, 32'h1, 32'h1, 1'b1, abi_pkg::ST_ORDER, 32'h0},
      '{abi_pkg::REQ_DEFINE, 24'h008000, 32'h00000000, 32'h7FFFFFFF, 1'b1,
        abi_pkg::ST_OK, 32'h0},
      '{abi_pkg::REQ_QUERY,  24'h008000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_QUERY,  24'h000001, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,
        32'hFFFFFFFF},
      '{abi_pkg::REQ_DEFINE, 24'h010000, 32'h12345678, 32'hFFFF0000, 1'b1,
        abi_pkg::ST_OK, 32'h0},
      '{abi_pkg::REQ_QUERY,  24'h010000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,
        32'h12345678},
      '{abi_pkg::REQ_QUERY,  24'h00C000, 32'h0, 32'h0, 1'b0, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_QUERY,  24'hFFFFFF, 32'h0, 32'h0, 1'b0, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_DEFINE, 24'h000100, 32'h0, 32'h0, 1'b1, abi_pkg::ST_ORDER, 32'h0},
      '{abi_pkg::REQ_CLEAR,  24'hABCDEF, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_QUERY,  24'h000000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_EMPTY, 32'h0},
      '{abi_pkg::REQ_DEFINE, 24'h001000, 32'h00010000, 32'h00020000, 1'b1,
        abi_pkg::ST_OK, 32'h0},
      '{abi_pkg::REQ_DEFINE, 24'h005000, 32'hFFFFFFFF, 32'hFFFE0000, 1'b1,
        abi_pkg::ST_OK, 32'h0},
      '{abi_pkg::REQ_QUERY,  24'h000800, 32'h0, 32'h0, 1'b0, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_QUERY,  24'h003000, 32'h0, 32'h0, 1'b0, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_QUERY,  24'h00F000, 32'h0, 32'h0, 1'b0, abi_pkg::ST_OK,    32'h0},
      '{abi_pkg::REQ_CLEAR,  24'h000000, 32'h0, 32'h0, 1'b1, abi_pkg::ST_OK,    32'h0}
   };

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // Fills the table with a sorted random sequence, possibly with duplicates.
   task automatic build_table(int entries, bit overfill);
      logic [23:0] p;
      int at;
      send_request(make_request(abi_pkg::REQ_CLEAR, 24'($urandom())));
      at = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(3000, 0);
      for (int i = 0; i < entries; i++) begin
         p = {8'($urandom_range(255, 0)), 16'(at)};
         if ($urandom_range(9, 0) == 0) p = abi_pkg::FRAC_ONE;
         send_request(make_request(abi_pkg::REQ_DEFINE, p));
         if ($urandom_range(4, 0) != 0)
            at = at + $urandom_range(65535 / (entries + 1), 0);
         if (at > 65535) at = 65535;
      end
      if (overfill) send_request(make_request(abi_pkg::REQ_DEFINE, 24'hFFFFFF));
   endtask

   task automatic random_phase(int items);
      int first;
      abi_tb_pkg::lookup_request_type q;
      logic [15:0] pick;
      first = accepted_requests;
      while (accepted_requests - first < items) begin
         build_table($urandom_range(9, 0) == 0 ? 16 : $urandom_range(6, 1),
                     $urandom_range(5, 0) == 0);
         for (int i = 0; i < 6; i++) begin
            q = make_request(abi_pkg::REQ_QUERY, 24'($urandom()));
            case ($urandom_range(5, 0))
               0: q.position = abi_pkg::FRAC_ONE;
               1: if (tbl_count > 0) begin
                  pick = tbl_pos[$urandom_range(tbl_count - 1, 0)];
                  q.position = {8'($urandom_range(255, 0)), pick};
               end
               2: q.position[15:0] = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
               3: if ($urandom_range(3, 0) == 0) q.kind = abi_pkg::REQ_NOP;
               4: if ($urandom_range(3, 0) == 0)
                  q.kind = abi_pkg::REQ_DEFINE;
               default: ;
            endcase
            send_request(q);
         end
      end
   endtask

   initial begin
      directed_row_type row;
      abi_tb_pkg::lookup_request_type q;
      req_chan.valid = 1'b0;
      req_chan.req_type = abi_pkg::REQ_NOP;
      req_chan.position = '0;
      req_chan.aperture_one = '0;
      req_chan.aperture_two = '0;
      req_chan.aperture_three = '0;
      req_chan.aperture_four = '0;
      req_chan.offset_x = '0;
      req_chan.offset_y = '0;
      rsp_chan.ready = 1'b1;
      tbl_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         q.kind = row.kind;
         q.position = row.position;
         for (int j = 0; j < 4; j++) q.aperture[j] = row.ap ^ (32'(j) << 28);
         q.aperture[0] = row.ap;
         q.off_x = row.off;
         q.off_y = ~row.off;
         send_request(q, row.typed, row.status, row.want_ap);
      end
      wait_drained();

      idle_send_pct = 0;  stall_recv_pct = 0;  random_phase(130);
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      idle_send_pct = 71; stall_recv_pct = 0;  random_phase(120);
      idle_send_pct = 0;  stall_recv_pct = 71; random_phase(120);
      idle_send_pct = 19; stall_recv_pct = 19; random_phase(130);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Covered %0d request items (%0d queries), %0d responses checked.",
               accepted_requests, query_count, checked_answers);
      if (error_count == 0) begin
         $display("PASS aperture_breakpoint_interpolator");
      end else begin
         $display("FAIL aperture_breakpoint_interpolator");
      end
      $finish;
   end

endmodule
